[hdl/srof_pkg.sv]
package srof_pkg;

  localparam int BYTE_W     = 8;
  localparam int REQ_BYTES  = 9;
  localparam int POL_LOW_W  = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int FF_BYTES   = 3;
  localparam int CARRY_BITS = 2;

  localparam logic [BYTE_W-1:0] PREV_SET   = 8'hFF;
  localparam logic [BYTE_W-1:0] PREV_CLEAR = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOARD_COUNT = 2'd0,
    CFG_POL_LOW     = 2'd1,
    CFG_POL_HIGH    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] vec;
    logic [BYTE_W-1:0] work;
    logic              diff;
  } lane_out_t;

  function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    r = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      r[BYTE_W-1-b] = v[b];
    end
    return r;
  endfunction

endpackage

[hdl/srof_lane.sv]
module srof_lane
  import srof_pkg::*;
(
  input  logic [BYTE_W-1:0] req,
  input  logic [BYTE_W-1:0] pol,
  input  logic [BYTE_W-1:0] prev,
  input  logic [BYTE_W-1:0] low_vec,
  input  logic              active,
  input  logic              shift_en,
  output lane_out_t         res
);

  logic [BYTE_W-1:0] vec;

  assign vec = req ^ pol;

  always_comb begin
    res.vec  = vec;
    // board pair shift: two top bits of the byte below move in at the bottom
    res.work = shift_en ? {vec[BYTE_W-CARRY_BITS-1:0], low_vec[BYTE_W-1 -: CARRY_BITS]}
                        : vec;
    res.diff = active && (vec != prev);
  end

endmodule

[hdl/srof_emit.sv]
module srof_emit
  import srof_pkg::*;
#(
  parameter int MAX_BYTES = 9
)
(
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_valid,
  output logic                               s_ready,
  input  lane_out_t                          lanes [MAX_BYTES],
  input  logic [$clog2(MAX_BYTES+1)-1:0]     act,
  output logic [BYTE_W-1:0]                  prev [MAX_BYTES],
  output logic                               m_valid,
  input  logic                               m_ready,
  output logic [BYTE_W-1:0]                  m_data,
  output logic                               m_last
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W-1:0] obuf      [MAX_BYTES];
  logic [BYTE_W-1:0] obuf_next [MAX_BYTES];
  logic              changed;
  logic              load;
  logic              take;

  // merge of the lane compare results
  always_comb begin
    changed = 1'b0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      changed = changed | lanes[i].diff;
    end
  end

  assign m_valid = (cnt != '0);
  assign m_last  = (cnt == CNT_W'(1));
  assign m_data  = obuf[0];
  assign take    = m_valid && m_ready;
  assign s_ready = (cnt == '0) || (m_last && m_ready);
  assign load    = s_valid && s_ready && changed;

  // highest active byte goes out first
  always_comb begin
    logic [CNT_W-1:0] sel;
    for (int p = 0; p < MAX_BYTES; p++) begin
      sel = act - CNT_W'(1) - CNT_W'(p);
      if (CNT_W'(p) < act) begin
        obuf_next[p] = flip8(lanes[sel[IDX_W-1:0]].work);
      end else begin
        obuf_next[p] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
        prev[i] <= (i < FF_BYTES) ? PREV_SET : PREV_CLEAR;
      end
    end else if (load) begin
      cnt <= act;
      for (int i = 0; i < MAX_BYTES; i++) begin
        if (CNT_W'(i) < act) begin
          prev[i] <= lanes[i].vec;
        end
      end
    end else if (take) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obuf <= obuf_next;
    end else if (take) begin
      for (int p = 0; p < MAX_BYTES - 1; p++) begin
        obuf[p] <= obuf[p+1];
      end
    end
  end

endmodule

[hdl/shift_register_output_refresh_top.sv]
// channel   | handshake          | payload
// s (in)    | s_tvalid/s_tready  | s_tdata: byte_0 .. byte_8, 8 bits each
// m (out)   | m_tvalid/m_tready  | m_tdata: serial_byte, m_tlast: latch_now
// cfg       | cfg_we             | cfg_index, cfg_data
// a request that matches the stored vector is taken and gives nothing
// a changed request gives 2*board_count+3 items (at most MAX_BYTES), one per cycle while m_tready is high
// the next request is taken in the cycle the last byte of a refresh is taken
// the output buffer register sets the rate: it holds one refresh at a time
// rst is synchronous; stored vector resets to bytes 0-2 all ones, others zero
// a stalled output holds its item; input waits until the buffer drains
module shift_register_output_refresh_top
  import srof_pkg::*;
#(
  parameter int MAX_BYTES = 9
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [71:0]           s_tdata,   // byte_0 .. byte_8
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // serial_byte
  output logic                  m_tlast,   // latch_now
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  logic [1:0]           board_count;
  logic [POL_LOW_W-1:0] pol_low;
  logic [BYTE_W-1:0]    pol_high;
  logic [3:0]           act_full;
  logic [CNT_W-1:0]     act;
  lane_out_t            lanes [MAX_BYTES];
  logic [BYTE_W-1:0]    prev  [MAX_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      board_count <= '0;
      pol_low     <= '0;
      pol_high    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOARD_COUNT: board_count <= cfg_data[1:0];
        CFG_POL_LOW:     pol_low     <= cfg_data[POL_LOW_W-1:0];
        CFG_POL_HIGH:    pol_high    <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign act_full = {1'b0, board_count, 1'b1} + 4'd2;
  assign act      = (act_full > 4'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : CNT_W'(act_full);

  for (genvar j = 0; j < MAX_BYTES; j++) begin : g_lane
    localparam int K = (j >= 1) ? (j - 1) / 2 : 0;
    logic [BYTE_W-1:0] pol;
    logic [BYTE_W-1:0] low_vec;
    logic              shift_en;

    if (j < 8) begin : g_pl
      assign pol = pol_low[BYTE_W*j +: BYTE_W];
    end else begin : g_ph
      assign pol = pol_high;
    end

    if (j >= 3) begin : g_sh
      assign shift_en = (2'(K) <= board_count) && (CNT_W'(2*K+2) < act);
    end else begin : g_ns
      assign shift_en = 1'b0;
    end

    if (j >= 1) begin : g_lo
      assign low_vec = lanes[j-1].vec;
    end else begin : g_l0
      assign low_vec = '0;
    end

    srof_lane u_lane (
      .req      (s_tdata[BYTE_W*j +: BYTE_W]),
      .pol      (pol),
      .prev     (prev[j]),
      .low_vec  (low_vec),
      .active   (CNT_W'(j) < act),
      .shift_en (shift_en),
      .res      (lanes[j])
    );
  end

  srof_emit #(
    .MAX_BYTES (MAX_BYTES)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .lanes   (lanes),
    .act     (act),
    .prev    (prev),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_data  (m_tdata),
    .m_last  (m_tlast)
  );

  // input never overwrites a refresh still being sent
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || (m_tlast && m_tready)))
    else $error("input taken while output buffer busy");

  // a refresh only ends on its latch byte
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tlast))
    else $error("refresh ended without latch byte");

  // a non-final byte taken is followed by more bytes
  a_frame_cont: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("refresh cut short");

endmodule

[tb/tb.sv]
module tb;
  import srof_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 65;
  localparam int PRESS_ITEMS  = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] sbyte;
    logic       latch;
  } serial_item_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [71:0]          data;
    logic                 typed;
    logic [3:0]           n_typed;
    logic [7:0]           fill;
  } dir_step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [71:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [1:0]  board_cnt;
  logic [63:0] pol_low;
  logic [7:0]  pol_high;
  logic [7:0]  prev_vec [REQ_BYTES];

  serial_item_t serial_exp_q [$];
  serial_item_t got_item;
  dir_step_t    dir_steps [$];
  logic [71:0]  last_req = '0;

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  src_idle_pct = 0;
  int  sink_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  shift_register_output_refresh_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  function automatic int active_bytes();
    int n;
    n = 2 * board_cnt + 3;
    if (n > REQ_BYTES) n = REQ_BYTES;
    return n;
  endfunction

  function automatic void predict_refresh(input logic [71:0] req, input logic emit);
    logic [7:0]   vec [REQ_BYTES];
    logic [7:0]   work [REQ_BYTES];
    logic [7:0]   pol;
    logic [7:0]   rev;
    logic [15:0]  pair;
    logic         changed;
    int           active;
    serial_item_t it;
    active = active_bytes();
    changed = 1'b0;
    for (int i = 0; i < active; i++) begin
      pol = (i < 8) ? pol_low[8*i +: 8] : pol_high;
      vec[i] = req[8*i +: 8] ^ pol;
      work[i] = vec[i];
      if (vec[i] != prev_vec[i]) changed = 1'b1;
    end
    if (changed) begin
      // board shift: each extension board eats the top two bits of the byte below it
      for (int k = board_cnt; k > 0; k--) begin
        if (2*k + 2 < active) begin
          pair = ({work[2*k+2], work[2*k+1]} << CARRY_BITS) | {14'd0, work[2*k][7:6]};
          work[2*k+2] = pair[15:8];
          work[2*k+1] = pair[7:0];
        end
      end
      for (int i = active - 1; i >= 0; i--) begin
        for (int b = 0; b < 8; b++) rev[7-b] = work[i][b];
        it.sbyte = rev;
        it.latch = (i == 0);
        if (emit) serial_exp_q.push_back(it);
        prev_vec[i] = vec[i];
      end
    end
  endfunction

  function automatic logic [71:0] next_request(input logic [71:0] last);
    logic [71:0] r;
    int          sel;
    int          idx;
    int          active;
    active = active_bytes();
    sel = $urandom_range(99);
    r = last;
    if (sel < 35) begin
      r = last;
    end else if (sel < 55) begin
      idx = $urandom_range(active - 1);
      r[8*idx +: 8] = last[8*idx +: 8] ^ 8'($urandom_range(255, 1));
    end else if (sel < 65 && active < REQ_BYTES) begin
      idx = $urandom_range(REQ_BYTES - 1, active);
      r[8*idx +: 8] = 8'($urandom);
    end else if (sel < 70) begin
      r = $urandom_range(1) ? '1 : '0;
    end else begin
      r = {8'($urandom), $urandom, $urandom};
    end
    return r;
  endfunction

  function automatic dir_step_t mk_req(input logic [71:0] data, input logic typed,
                                       input logic [3:0] n, input logic [7:0] fill);
    dir_step_t s;
    s = '0;
    s.data = data;
    s.typed = typed;
    s.n_typed = n;
    s.fill = fill;
    return s;
  endfunction

  function automatic dir_step_t mk_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    dir_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = {8'h00, v};
    return s;
  endfunction

  task automatic offer_request(input logic [71:0] req);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_req = req;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BOARD_COUNT: board_cnt = v[1:0];
      CFG_POL_LOW:     pol_low = v;
      CFG_POL_HIGH:    pol_high = v[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (serial_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(input int n, input logic force_change);
    logic [71:0] r;
    repeat (n) begin
      r = force_change ? {8'($urandom), $urandom, $urandom} : next_request(last_req);
      offer_request(r);
      predict_refresh(r, 1'b1);
    end
  endtask

  // receiver side, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
        $display("[FAIL] regression broken");
        $finish;
      end else if (m_tvalid && m_tready) begin
        if (serial_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item %02h last %0b", m_tdata, m_tlast));
        end else begin
          got_item = serial_exp_q.pop_front();
          if (m_tdata !== got_item.sbyte)
            report_mismatch($sformatf("serial_byte %02h, want %02h", m_tdata, got_item.sbyte));
          if (m_tlast !== got_item.latch)
            report_mismatch($sformatf("latch_now %0b, want %0b", m_tlast, got_item.latch));
        end
      end
    end
  end

  initial begin
    dir_step_t st;
    board_cnt = '0;
    pol_low = '0;
    pol_high = '0;
    for (int i = 0; i < REQ_BYTES; i++) prev_vec[i] = (i < FF_BYTES) ? PREV_SET : PREV_CLEAR;

    // reset state, one board row of three bytes
    dir_steps.push_back(mk_req('1, 1'b1, 4'd0, 8'h00));
    dir_steps.push_back(mk_req('0, 1'b1, 4'd3, 8'h00));
    dir_steps.push_back(mk_req('0, 1'b1, 4'd0, 8'h00));
    dir_steps.push_back(mk_req(72'hFF_FFFF_FFFF_FF00_0000, 1'b1, 4'd0, 8'h00));
    dir_steps.push_back(mk_req(72'h00_0000_0000_003C_5A81, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_req('0, 1'b1, 4'd3, 8'h00));
    // all boards, full inversion
    dir_steps.push_back(mk_cfg(CFG_BOARD_COUNT, 64'd3));
    dir_steps.push_back(mk_cfg(CFG_POL_LOW, '1));
    dir_steps.push_back(mk_cfg(CFG_POL_HIGH, 64'hFF));
    dir_steps.push_back(mk_req('1, 1'b1, 4'd0, 8'h00));
    dir_steps.push_back(mk_req('0, 1'b1, 4'd9, 8'hFF));
    dir_steps.push_back(mk_req('1, 1'b1, 4'd9, 8'h00));
    dir_steps.push_back(mk_req('1, 1'b1, 4'd0, 8'h00));
    dir_steps.push_back(mk_req(72'hAA_AAAA_AAAA_AAAA_AAAA, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_req(72'h55_5555_5555_5555_5555, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_req(72'hC0_C0C0_C0C0_C0C0_C0C0, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_req(72'h3F_3F3F_3F3F_3F3F_3F3F, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_req(72'h01_2345_6789_ABCD_EF5A, 1'b0, 4'd0, 8'h00));
    // shrink to the base board: the upper stored bytes must be kept
    dir_steps.push_back(mk_cfg(CFG_BOARD_COUNT, 64'd0));
    dir_steps.push_back(mk_cfg(CFG_POL_LOW, 64'd0));
    dir_steps.push_back(mk_cfg(CFG_POL_HIGH, 64'd0));
    dir_steps.push_back(mk_req(72'h12_3456_789A_BC01_0203, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_cfg(CFG_BOARD_COUNT, 64'd3));
    dir_steps.push_back(mk_req(72'h12_3456_789A_BC01_0203, 1'b0, 4'd0, 8'h00));
    // write to the unused index has no effect
    dir_steps.push_back(mk_cfg(CFG_BOARD_COUNT, 64'd1));
    dir_steps.push_back(mk_cfg(CFG_POL_LOW, 64'h5AA5_0FF0_C33C_9669));
    dir_steps.push_back(mk_cfg(CFG_UNUSED, '1));
    dir_steps.push_back(mk_cfg(CFG_POL_HIGH, 64'hA5));
    dir_steps.push_back(mk_req('0, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_req('1, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_req(72'h80_0000_0000_0000_00C1, 1'b0, 4'd0, 8'h00));
    dir_steps.push_back(mk_cfg(CFG_BOARD_COUNT, 64'd2));
    dir_steps.push_back(mk_req(72'h7E_81C3_3CFF_00E7_18C0, 1'b0, 4'd0, 8'h00));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      st = dir_steps[i];
      if (st.is_cfg) begin
        wait_idle();
        write_reg(st.idx, st.data[63:0]);
      end else begin
        offer_request(st.data);
        predict_refresh(st.data, !st.typed);
        if (st.typed) begin
          for (int j = int'(st.n_typed) - 1; j >= 0; j--)
            serial_exp_q.push_back('{sbyte: st.fill, latch: (j == 0)});
        end
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          write_reg(CFG_BOARD_COUNT, 64'd0);
          write_reg(CFG_POL_LOW, 64'd0);
          write_reg(CFG_POL_HIGH, 64'd0);
        end
        1: begin
          src_idle_pct = 62;
          sink_stall_pct = 0;
          write_reg(CFG_BOARD_COUNT, 64'd3);
          write_reg(CFG_POL_LOW, {$urandom, $urandom});
          write_reg(CFG_POL_HIGH, 64'($urandom_range(255)));
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 62;
          write_reg(CFG_BOARD_COUNT, 64'd2);
          write_reg(CFG_POL_LOW, '1);
          write_reg(CFG_POL_HIGH, 64'($urandom_range(255)));
        end
        default: begin
          src_idle_pct = 13;
          sink_stall_pct = 13;
          write_reg(CFG_BOARD_COUNT, 64'd1);
          write_reg(CFG_POL_LOW, {$urandom, $urandom});
          write_reg(CFG_POL_HIGH, 64'hFF);
        end
      endcase
      send_random(RAND_ITEMS, 1'b0);
    end

    // receiver holds off while every request changes the vector
    wait_idle();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_reg(CFG_BOARD_COUNT, 64'd3);
    hold_req = 1'b1;
    send_random(PRESS_ITEMS, 1'b1);

    wait_idle();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
